>>> design/small_integer_set_ordered_top_macros.svh
// Assertion macros for the ordered small-integer set.
// Taken in by the top level; no other dependencies.
`ifndef SMALL_INTEGER_SET_ORDERED_TOP_MACROS_SVH
`define SMALL_INTEGER_SET_ORDERED_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked out of reset
`define SISORD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sisord assertion failed");
// next-cycle implication, checked out of reset
`define SISORD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sisord assertion failed");
`else
`define SISORD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SISORD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/sisord_pkg.sv
// Shared types and constants for the ordered small-integer set.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package sisord_pkg;

  localparam int unsigned SET_SIZE_DEF = 32;
  localparam int unsigned CNT_W        = 6;

  // request type codes
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_CHECK  = 3'd2;
  localparam logic [2:0] REQ_TOGGLE = 3'd3;
  localparam logic [2:0] REQ_FILL   = 3'd4;
  localparam logic [2:0] REQ_CLEAR  = 3'd5;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ARG   = 2'd2;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             is_member;
    logic [CNT_W-1:0] member_count;
    logic [CNT_W-1:0] element;
    logic             element_valid;
    logic             last;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic latch;
    logic insert;
    logic srch_init;
    logic srch;
    logic srch_fin;
    logic fill_init;
    logic fill;
    logic clear;
    logic emit_init;
    logic emit;
    logic single;
  } ctl_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic bad;
    logic single;
    logic ins;
    logic del;
    logic fill;
    logic clear;
    logic srch_done;
    logic fill_done;
    logic emit_done;
    logic single_done;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> design/small_integer_set_ordered_top.sv
// Ordered small-integer set over 1..SET_SIZE: bitset plus insertion-order list.
//
// Request channel (in_valid_i/in_ready_o, in_req_i) takes one request at a
// time: add, remove, check, toggle, fill all, clear. Result channel
// (out_valid_o/out_ready_i, out_rsp_o) returns the list after each request
// except check, one element per result with last set on the final one; an
// empty list, a check or a rejected request gives a single result.
// Unknown request types are dropped with no result.
// Sequence: a request is latched and decoded; a single result is then
// registered in the output register, while each list element passes the
// memory read stage and then the output register. The list streams one
// element per cycle while the receiver is ready. Removal first scans and
// compacts the list through the one-read, one-write list memory; fill all
// writes that memory one entry a cycle.
// in_ready_o is high only between requests. The last result sits in the
// output register while the next request is taken; a stalled receiver holds
// the stream in place with nothing dropped.
// Reset empties the set at once; the list memory needs no clearing pass.
// Depends on sisord_pkg, sisord_ctrl, sisord_dp and the macros header.
`default_nettype none

`include "small_integer_set_ordered_top_macros.svh"

module small_integer_set_ordered_top #(
  parameter int unsigned SET_SIZE = sisord_pkg::SET_SIZE_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  sisord_pkg::req_t in_req_i,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  output sisord_pkg::rsp_t out_rsp_o
);
  import sisord_pkg::*;

  ctl_cmd_t            cmd;
  dp_stat_t            stat;
  logic [SET_SIZE-1:0] members;
  logic [CNT_W-1:0]    len;

  sisord_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sisord_dp #(
    .SET_SIZE (SET_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .members_o   (members),
    .len_o       (len)
  );

  // between requests, the list length matches the membership bits
  `SISORD_ASSERT_IMPL(a_len_matches_bits, clk_i, rst_ni, in_ready_o, $countones(members) == int'(len))
  // a taken request keeps the block busy in the next cycle
  `SISORD_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // the list never outgrows the set
  `SISORD_ASSERT_IMPL(a_len_bound, clk_i, rst_ni, out_valid_o && out_rsp_o.element_valid, out_rsp_o.member_count != '0 && int'(out_rsp_o.member_count) <= SET_SIZE)

endmodule

`default_nettype wire

>>> design/sisord_ctrl.sv
// Sequencing state machine for the ordered small-integer set.
// Depends on sisord_pkg for the command and status structs.
`default_nettype none

module sisord_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  sisord_pkg::dp_stat_t stat_i,
  output sisord_pkg::ctl_cmd_t cmd_o
);
  import sisord_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_FILL   = 6'b001000,
    S_EMIT   = 6'b010000,
    S_SINGLE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.bad) begin
          state_d = S_IDLE;
        end else if (stat_i.single) begin
          state_d = S_SINGLE;
        end else if (stat_i.fill) begin
          cmd_o.fill_init = 1'b1;
          state_d         = S_FILL;
        end else if (stat_i.del) begin
          cmd_o.srch_init = 1'b1;
          state_d         = S_SEARCH;
        end else begin
          cmd_o.insert    = stat_i.ins;
          cmd_o.clear     = stat_i.clear;
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_SEARCH: begin
        cmd_o.srch = 1'b1;
        if (stat_i.srch_done) begin
          cmd_o.srch_fin  = 1'b1;
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (stat_i.fill_done) begin
          cmd_o.emit_init = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_done) begin
          state_d = S_IDLE;
        end
      end
      S_SINGLE: begin
        cmd_o.single = 1'b1;
        if (stat_i.single_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> design/sisord_dp.sv
// Datapath of the ordered small-integer set: membership bits, list memory,
// read pipeline and output register. Depends on sisord_pkg.
`default_nettype none

module sisord_dp #(
  parameter int unsigned SET_SIZE = sisord_pkg::SET_SIZE_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  sisord_pkg::req_t           in_req_i,
  input  sisord_pkg::ctl_cmd_t       cmd_i,
  output sisord_pkg::dp_stat_t       stat_o,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output sisord_pkg::rsp_t           out_rsp_o,
  output logic [SET_SIZE-1:0]        members_o,
  output logic [sisord_pkg::CNT_W-1:0] len_o
);
  import sisord_pkg::*;

  localparam int unsigned IW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam logic [CNT_W-1:0] N_C = CNT_W'(SET_SIZE);
  localparam logic [7:0] N_V = 8'(SET_SIZE);

  // list memory and read data
  logic [CNT_W-1:0] order_mem [SET_SIZE];
  logic [CNT_W-1:0] rd_data_q;

  // control state
  logic [SET_SIZE-1:0] bits_q;
  logic [CNT_W-1:0]    len_q;
  logic [CNT_W-1:0]    ptr_q;
  logic                s1_v_q, s1_last_q, found_q, o_v_q;

  // payload state
  logic [2:0]    req_q;
  logic [7:0]    val_q;
  logic [IW-1:0] j_q;
  rsp_t          rsp_q;

  logic [CNT_W-1:0] v6;
  logic [IW-1:0]    bidx;
  logic             in_range, member, has_room;
  logic [1:0]       sgl_status;
  logic             sgl_member;
  logic             out_free, s1_take, emit_issue, srch_issue, rd_en, empty_take;
  logic             srch_wr, o_load;
  logic             wr_en;
  logic [IW-1:0]    wr_addr, rd_addr;
  logic [CNT_W-1:0] wr_data;

  assign v6       = val_q[CNT_W-1:0];
  assign bidx     = IW'(v6 - CNT_W'(1));
  assign in_range = (val_q != 8'd0) && (val_q <= N_V);
  assign member   = bits_q[bidx];
  assign has_room = (len_q < N_C);

  // request decode
  always_comb begin
    stat_o     = '0;
    sgl_status = ST_OK;
    sgl_member = 1'b0;
    case (req_q)
      REQ_ADD: begin
        stat_o.single = !in_range;
        sgl_status    = ST_RANGE;
        stat_o.ins    = in_range && !member && has_room;
      end
      REQ_REMOVE: begin
        stat_o.single = !in_range;
        sgl_status    = ST_RANGE;
        stat_o.del    = in_range && member;
      end
      REQ_CHECK: begin
        stat_o.single = 1'b1;
        sgl_status    = in_range ? ST_OK : ST_RANGE;
        sgl_member    = in_range && member;
      end
      REQ_TOGGLE: begin
        stat_o.single = !in_range;
        sgl_status    = ST_RANGE;
        stat_o.ins    = in_range && !member && has_room;
        stat_o.del    = in_range && member;
      end
      REQ_FILL: begin
        stat_o.single = (val_q != 8'd0);
        sgl_status    = ST_ARG;
        stat_o.fill   = (val_q == 8'd0);
      end
      REQ_CLEAR: begin
        stat_o.single = (val_q != 8'd0);
        sgl_status    = ST_ARG;
        stat_o.clear  = (val_q == 8'd0);
      end
      default: begin
        stat_o.bad = 1'b1;
      end
    endcase

    stat_o.srch_done   = cmd_i.srch && s1_v_q && s1_last_q;
    stat_o.fill_done   = cmd_i.fill && (ptr_q == N_C - CNT_W'(1));
    stat_o.emit_done   = empty_take || (s1_take && s1_last_q);
    stat_o.single_done = cmd_i.single && out_free;
  end

  // read pipeline: memory read stage then output register
  assign out_free   = !o_v_q || out_ready_i;
  assign s1_take    = cmd_i.emit && s1_v_q && out_free;
  assign emit_issue = cmd_i.emit && (ptr_q < len_q) && (!s1_v_q || s1_take);
  assign srch_issue = cmd_i.srch && (ptr_q < len_q);
  assign rd_en      = emit_issue || srch_issue;
  assign rd_addr    = IW'(ptr_q);
  assign empty_take = cmd_i.emit && (len_q == '0) && out_free;
  assign srch_wr    = cmd_i.srch && s1_v_q && found_q;
  assign o_load     = s1_take || empty_take || stat_o.single_done;

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = IW'(len_q);
    wr_data = v6;
    if (cmd_i.insert) begin
      wr_en = 1'b1;
    end else if (cmd_i.fill) begin
      wr_en   = 1'b1;
      wr_addr = IW'(ptr_q);
      wr_data = ptr_q + CNT_W'(1);
    end else if (srch_wr) begin
      wr_en   = 1'b1;
      wr_addr = j_q - IW'(1);
      wr_data = rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      order_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= order_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q    <= '0;
      len_q     <= '0;
      ptr_q     <= '0;
      s1_v_q    <= 1'b0;
      s1_last_q <= 1'b0;
      found_q   <= 1'b0;
      o_v_q     <= 1'b0;
    end else begin
      // membership and length
      if (cmd_i.insert) begin
        bits_q[bidx] <= 1'b1;
        len_q        <= len_q + CNT_W'(1);
      end else if (cmd_i.srch_init) begin
        bits_q[bidx] <= 1'b0;
      end else if (cmd_i.srch_fin) begin
        len_q <= len_q - CNT_W'(1);
      end else if (cmd_i.fill_init) begin
        bits_q <= '1;
        len_q  <= N_C;
      end else if (cmd_i.clear) begin
        bits_q <= '0;
        len_q  <= '0;
      end

      // position counter
      if (cmd_i.emit_init || cmd_i.srch_init || cmd_i.fill_init) begin
        ptr_q <= '0;
      end else if (rd_en || cmd_i.fill) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end

      // read stage valid
      if (cmd_i.emit_init || cmd_i.srch_init) begin
        s1_v_q <= 1'b0;
      end else if (cmd_i.srch) begin
        s1_v_q <= srch_issue;
      end else if (emit_issue) begin
        s1_v_q <= 1'b1;
      end else if (s1_take) begin
        s1_v_q <= 1'b0;
      end
      if (rd_en) begin
        s1_last_q <= (ptr_q == len_q - CNT_W'(1));
      end

      // match found during removal search
      if (cmd_i.srch_init) begin
        found_q <= 1'b0;
      end else if (cmd_i.srch && s1_v_q && (rd_data_q == v6)) begin
        found_q <= 1'b1;
      end

      // output register valid
      if (o_load) begin
        o_v_q <= 1'b1;
      end else if (out_ready_i) begin
        o_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= in_req_i.req_type;
      val_q <= in_req_i.value;
    end
    if (rd_en) begin
      j_q <= IW'(ptr_q);
    end
    if (s1_take) begin
      rsp_q.status        <= ST_OK;
      rsp_q.is_member     <= 1'b0;
      rsp_q.member_count  <= len_q;
      rsp_q.element       <= rd_data_q;
      rsp_q.element_valid <= 1'b1;
      rsp_q.last          <= s1_last_q;
    end else if (o_load) begin
      rsp_q.status        <= cmd_i.single ? sgl_status : ST_OK;
      rsp_q.is_member     <= cmd_i.single && sgl_member;
      rsp_q.member_count  <= len_q;
      rsp_q.element       <= '0;
      rsp_q.element_valid <= 1'b0;
      rsp_q.last          <= 1'b1;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_rsp_o   = rsp_q;
  assign members_o   = bits_q;
  assign len_o       = len_q;

endmodule

`default_nettype wire
